// ----- hdl/mflt_pkg.sv -----
// shared types and constants for the motor feedback link tracker
`timescale 1ns / 1ps
`default_nettype none
package mflt_pkg;

   localparam int unsigned DATA_W      = 16;
   localparam int unsigned TURN_W      = 32;
   localparam int unsigned SILENCE_W   = 17;
   localparam int unsigned LIMIT_W     = 15;
   localparam int unsigned CSR_ADDR_W  = 1;

   localparam logic [DATA_W-1:0]    LOW_ZONE      = 16'd2048;
   localparam logic [DATA_W-1:0]    HIGH_ZONE     = 16'd6144;
   localparam logic [SILENCE_W-1:0] SILENCE_MAX   = 17'h1FFFF;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 15'd10000;
   localparam logic [DATA_W-1:0]    TIMEOUT_RESET = 16'd5000;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_FRAME = 2'd1,
      CMD_REQ   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CURRENT_LIMIT = 1'b0,
      CSR_TIMEOUT       = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      MODE_DISC = 3'b001,
      MODE_IDLE = 3'b010,
      MODE_RUN  = 3'b100
   } mode_type;

   localparam logic [1:0] LINK_DISC = 2'd0;
   localparam logic [1:0] LINK_IDLE = 2'd1;
   localparam logic [1:0] LINK_RUN  = 2'd2;

   typedef struct packed {
      logic [LIMIT_W-1:0] current_limit;
      logic [DATA_W-1:0]  timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive_current;
      logic [1:0]               link_state;
      logic                     connected;
      logic [DATA_W-1:0]        angle_now;
      logic signed [DATA_W-1:0] velocity_now;
      logic signed [DATA_W-1:0] current_now;
      logic signed [TURN_W-1:0] turn_count;
   } rsp_type;

   function automatic logic [1:0] link_code(input mode_type mode);
      logic [1:0] code;
      unique case (mode)
         MODE_IDLE: code = LINK_IDLE;
         MODE_RUN:  code = LINK_RUN;
         default:   code = LINK_DISC;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/mflt_if.sv -----
// channel interfaces: request, response and register write
`timescale 1ns / 1ps
`default_nettype none
interface mflt_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [15:0]       feedback_angle;
   logic signed [15:0] feedback_velocity;
   logic signed [15:0] feedback_current;
   logic signed [15:0] requested_current;
   modport source(output valid, cmd, feedback_angle, feedback_velocity, feedback_current,
                  requested_current, input ready);
   modport sink(input valid, cmd, feedback_angle, feedback_velocity, feedback_current,
                requested_current, output ready);
endinterface

interface mflt_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] drive_current;
   logic [1:0]        link_state;
   logic              connected;
   logic [15:0]       angle_now;
   logic signed [15:0] velocity_now;
   logic signed [15:0] current_now;
   logic signed [31:0] turn_count;
   modport source(output valid, drive_current, link_state, connected, angle_now,
                  velocity_now, current_now, turn_count, input ready);
   modport sink(input valid, drive_current, link_state, connected, angle_now,
                velocity_now, current_now, turn_count, output ready);
endinterface

interface mflt_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  addr;
   logic [15:0] wdata;
   modport source(output valid, addr, wdata, input ready);
   modport sink(input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

// ----- hdl/motor_feedback_link_tracker.sv -----
// Link tracker for one CAN motor: takes ticks, feedback frames, current requests
// and turn-count resets, one beat per clock, and returns one result beat per
// request beat holding the state after that update. A request beat is held in
// the input register, its update is computed combinationally from it and lands in
// the result register, from which the result beat is presented on rsp_bus;
// throughput is one beat per cycle as long as the response side keeps taking
// beats, and req_bus.ready follows rsp_bus.ready combinationally through the two
// registers. Register writes on csr_bus are always ready and take effect on the
// next cycle.
`timescale 1ns / 1ps
`default_nettype none
module motor_feedback_link_tracker
   import mflt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mflt_req_if.sink    req_bus,
   mflt_rsp_if.source  rsp_bus,
   mflt_csr_if.sink    csr_bus
);

   cfg_type cfg;
   logic    take;
   logic    res_valid;
   rsp_type res_data;

   mflt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   mflt_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg),
      .take      (take),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   mflt_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_data  (res_data),
      .take      (take),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

// ----- hdl/mflt_csr.sv -----
// configuration registers: current limit and silence timeout
`timescale 1ns / 1ps
`default_nettype none
module mflt_csr
   import mflt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mflt_csr_if.sink    csr_bus,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_idx_type'(csr_bus.addr))
            CSR_CURRENT_LIMIT: cfg_in.current_limit = csr_bus.wdata[LIMIT_W-1:0];
            CSR_TIMEOUT:       cfg_in.timeout_ticks = csr_bus.wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_limit <= LIMIT_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- hdl/mflt_tracker.sv -----
// input register and link / turn tracking state update
`timescale 1ns / 1ps
`default_nettype none
module mflt_tracker
   import mflt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mflt_req_if.sink    req_bus,
   input  wire cfg_type cfg,
   input  wire logic   take,
   output logic        res_valid,
   output rsp_type     res_data
);

   // input register
   logic                     s1_valid_ff, s1_valid_in;
   cmd_type                  s1_cmd_ff;
   logic [DATA_W-1:0]        s1_angle_ff;
   logic signed [DATA_W-1:0] s1_velocity_ff;
   logic signed [DATA_W-1:0] s1_current_ff;
   logic signed [DATA_W-1:0] s1_request_ff;

   // tracker state
   mode_type                 mode_ff, mode_in;
   logic signed [DATA_W-1:0] target_ff, target_in;
   logic [DATA_W-1:0]        angle_ff, angle_in;
   logic signed [DATA_W-1:0] velocity_ff, velocity_in;
   logic signed [DATA_W-1:0] measured_ff, measured_in;
   logic [TURN_W-1:0]        turns_ff, turns_in;
   logic [SILENCE_W-1:0]     since_ff, since_in;
   logic                     seen_ff, seen_in;

   logic                     load;
   logic                     adv;
   logic [SILENCE_W-1:0]     since_inc;
   logic signed [DATA_W:0]   lim_ext;
   logic signed [DATA_W:0]   lim_neg;
   logic signed [DATA_W:0]   req_ext;
   logic signed [DATA_W-1:0] clamped;

   assign adv           = s1_valid_ff & take;
   assign req_bus.ready = ~s1_valid_ff | take;
   assign load          = req_bus.valid & req_bus.ready;
   assign s1_valid_in   = load | (s1_valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_cmd_ff      <= CMD_TICK;
      end else if (load) begin
         s1_cmd_ff      <= cmd_type'(req_bus.cmd);
         s1_angle_ff    <= req_bus.feedback_angle;
         s1_velocity_ff <= req_bus.feedback_velocity;
         s1_current_ff  <= req_bus.feedback_current;
         s1_request_ff  <= req_bus.requested_current;
      end
   end

   // saturating silence count and symmetric clamp
   assign since_inc = (since_ff != SILENCE_MAX) ? since_ff + 1'b1 : since_ff;
   assign lim_ext   = signed'({2'b00, cfg.current_limit});
   assign lim_neg   = -lim_ext;
   assign req_ext   = signed'({s1_request_ff[DATA_W-1], s1_request_ff});

   always_comb begin
      if (req_ext > lim_ext) begin
         clamped = lim_ext[DATA_W-1:0];
      end else if (req_ext < lim_neg) begin
         clamped = lim_neg[DATA_W-1:0];
      end else begin
         clamped = s1_request_ff;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      target_in   = target_ff;
      angle_in    = angle_ff;
      velocity_in = velocity_ff;
      measured_in = measured_ff;
      turns_in    = turns_ff;
      since_in    = since_ff;
      seen_in     = seen_ff;
      unique case (s1_cmd_ff)
         CMD_TICK: begin
            since_in = since_inc;
            if (since_inc > {1'b0, cfg.timeout_ticks}) begin
               mode_in   = MODE_DISC;
               target_in = '0;
            end
         end
         CMD_FRAME: begin
            angle_in    = s1_angle_ff;
            velocity_in = s1_velocity_ff;
            measured_in = s1_current_ff;
            since_in    = '0;
            seen_in     = 1'b1;
            if (mode_ff == MODE_DISC) begin
               mode_in = MODE_IDLE;
            end
            // zero crossing, skipped on the very first frame
            if (seen_ff) begin
               if (s1_angle_ff < LOW_ZONE && angle_ff > HIGH_ZONE) begin
                  turns_in = turns_ff + 1'b1;
               end else if (s1_angle_ff > HIGH_ZONE && angle_ff < LOW_ZONE) begin
                  turns_in = turns_ff - 1'b1;
               end
            end
         end
         CMD_REQ: begin
            if (mode_ff == MODE_IDLE) begin
               mode_in = MODE_RUN;
            end
            if (mode_ff != MODE_DISC) begin
               target_in = clamped;
            end
         end
         CMD_CLEAR: begin
            turns_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DISC;
         target_ff   <= '0;
         angle_ff    <= '0;
         velocity_ff <= '0;
         measured_ff <= '0;
         turns_ff    <= '0;
         since_ff    <= '0;
         seen_ff     <= 1'b0;
      end else if (adv) begin
         mode_ff     <= mode_in;
         target_ff   <= target_in;
         angle_ff    <= angle_in;
         velocity_ff <= velocity_in;
         measured_ff <= measured_in;
         turns_ff    <= turns_in;
         since_ff    <= since_in;
         seen_ff     <= seen_in;
      end
   end

   assign res_valid = s1_valid_ff;

   always_comb begin
      res_data.drive_current = (mode_in == MODE_DISC) ? '0 : target_in;
      res_data.link_state    = link_code(mode_in);
      res_data.connected     = (mode_in != MODE_DISC);
      res_data.angle_now     = angle_in;
      res_data.velocity_now  = velocity_in;
      res_data.current_now   = measured_in;
      res_data.turn_count    = signed'(turns_in);
   end

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DISC) |-> (target_ff == '0))
      else $error("target not zero while disconnected");

   assert property (@(posedge clock) disable iff (reset)
      (adv && s1_cmd_ff == CMD_FRAME) |=> (since_ff == '0 && mode_ff != MODE_DISC))
      else $error("frame did not restart silence count or connect link");

   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_RUN) |=> (mode_ff != MODE_IDLE))
      else $error("link fell back from running to idle");

   assert property (@(posedge clock) disable iff (reset)
      (!adv) |=> $stable(turns_ff) && $stable(mode_ff))
      else $error("state changed without a beat moving on");

endmodule
`default_nettype wire

// ----- hdl/mflt_rsp_reg.sv -----
// result register on the response channel
`timescale 1ns / 1ps
`default_nettype none
module mflt_rsp_reg
   import mflt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   res_valid,
   input  wire rsp_type res_data,
   output logic        take,
   mflt_rsp_if.source  rsp_bus
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign take     = ~valid_ff | rsp_bus.ready;
   assign valid_in = take ? res_valid : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         data_ff <= res_data;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.drive_current = data_ff.drive_current;
   assign rsp_bus.link_state    = data_ff.link_state;
   assign rsp_bus.connected     = data_ff.connected;
   assign rsp_bus.angle_now     = data_ff.angle_now;
   assign rsp_bus.velocity_now  = data_ff.velocity_now;
   assign rsp_bus.current_now   = data_ff.current_now;
   assign rsp_bus.turn_count    = data_ff.turn_count;

endmodule
`default_nettype wire
